// ===== design/srt_pkg.sv =====
package srt_pkg;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_READ    = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_ADDED          = 3'd0,
      ST_ADDED_COMPLETE = 3'd1,
      ST_DUP            = 3'd2,
      ST_DUP_COMPLETE   = 3'd3,
      ST_NO_ROOM        = 3'd4,
      ST_NOT_FOUND      = 3'd5,
      ST_RELEASED       = 3'd6,
      ST_SEGMENT        = 3'd7
   } status_type;

   // Command handed from the front to the table engine.
   typedef struct packed {
      action_type  action;
      logic [31:0] gen;
      logic [31:0] msg;
      logic [5:0]  seq;
      logic        fin;
      logic [15:0] handle;
      logic        too_big;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  seg;
      logic [15:0] handle;
      logic        last;
   } rsp_type;

endpackage

// ===== design/segment_reassembly_table.sv =====
// Segment reassembly table: tracks segmented messages by generator and
// message key in a bucketed, set-associative table.
// Input side is a queue: drive the req_ fields and push while full is low.
// Actions: insert a segment, read out a message, release a message; the
// unused action code is dropped and gives no result.
// Result side is a queue: while empty is low the oldest result sits on the
// rsp_ ports; pop takes it. last_of_run marks the final result of an item.
// The front hashes the key by a reciprocal multiply (HASH, then FOLD) and
// keeps full high until the item is sent to its queue, so it takes no new
// item before the last one is queued; a 2-deep queue feeds the table engine.
// The engine does insert or release in steps (row read, compare, write
// back); the result of an insert or release reaches the rsp_ ports through
// the result queue. Read-out steps through the sequence numbers from zero,
// emitting each stored segment and skipping each absent one below the
// highest; the engine takes a new item only when the last one is done.
// After reset the engine clears the table, one bucket a cycle, from bucket
// 0 up to BUCKETS-1; up to 3 items are taken meanwhile but not processed.
// When the receiver stops popping, the 4-deep result queue fills and the
// engine holds; the front then fills its queue and raises full.
module segment_reassembly_table #(
   parameter int BUCKETS      = 256,
   parameter int WAYS         = 4,
   parameter int MAX_SEGMENTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_generator_key,
   input  logic [31:0] req_message_key,
   input  logic [30:0] req_segment_number,
   input  logic        req_final_segment,
   input  logic [15:0] req_payload_handle,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_out_segment_number,
   output logic [15:0] rsp_out_payload_handle,
   output logic        rsp_last_of_run
);
   localparam int BW = $clog2(BUCKETS);
   localparam int RW = $bits(srt_pkg::rsp_type);

   logic             q_pop, q_empty;
   srt_pkg::cmd_type q_cmd;
   logic [BW-1:0]    q_bkt;
   logic             r_push, r_full;
   srt_pkg::rsp_type r_item, r_head;
   logic [RW-1:0]    r_rdata;

   srt_front #(.BUCKETS(BUCKETS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .action         (req_action),
      .generator_key  (req_generator_key),
      .message_key    (req_message_key),
      .segment_number (req_segment_number),
      .final_segment  (req_final_segment),
      .payload_handle (req_payload_handle),
      .q_pop          (q_pop),
      .q_empty        (q_empty),
      .q_cmd          (q_cmd),
      .q_bkt          (q_bkt)
   );

   srt_engine #(.BUCKETS(BUCKETS), .WAYS(WAYS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_engine (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_cmd   (q_cmd),
      .q_bkt   (q_bkt),
      .r_full  (r_full),
      .r_push  (r_push),
      .r_item  (r_item)
   );

   srt_fifo #(.WIDTH(RW), .DEPTH(4)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (r_push),
      .full  (r_full),
      .wdata (r_item),
      .pop   (pop),
      .empty (empty),
      .rdata (r_rdata)
   );

   assign r_head                 = r_rdata;
   assign rsp_status             = r_head.status;
   assign rsp_out_segment_number = r_head.seg;
   assign rsp_out_payload_handle = r_head.handle;
   assign rsp_last_of_run        = r_head.last;

endmodule

// ===== design/srt_fifo.sv =====
module srt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rdata   = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ===== design/srt_front.sv =====
module srt_front #(
   parameter int BUCKETS      = 256,
   parameter int MAX_SEGMENTS = 32,
   localparam int BW          = $clog2(BUCKETS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [1:0]          action,
   input  logic [31:0]         generator_key,
   input  logic [31:0]         message_key,
   input  logic [30:0]         segment_number,
   input  logic                final_segment,
   input  logic [15:0]         payload_handle,
   input  logic                q_pop,
   output logic                q_empty,
   output srt_pkg::cmd_type    q_cmd,
   output logic [BW-1:0]       q_bkt
);
   typedef enum logic [1:0] {IDLE, HASH, FOLD, SEND} state_type;

   localparam int QW = $bits(srt_pkg::cmd_type) + BW;
   // reciprocal of BUCKETS scaled by 2^(32+BW), rounded up: exact for 32-bit keys
   localparam logic [32:0] RECIP =
      33'(((65'd1 << (32 + BW)) + 65'(BUCKETS) - 65'd1) / 65'(BUCKETS));

   state_type         state_ff, state_in;
   logic [31:0]       key_ff, key_in;
   logic [31:0]       quo_ff, quo_in;
   logic [BW-1:0]     rem_ff, rem_in;
   srt_pkg::cmd_type  cmd_ff, cmd_in;
   logic              q_push, q_full;
   logic [QW-1:0]     q_rdata;

   always_comb begin
      logic [64:0] prod;
      prod     = 65'(key_ff) * 65'(RECIP);
      state_in = state_ff;
      key_in   = key_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cmd_in   = cmd_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         IDLE: begin
            // drop the unused action code here: it causes no result
            if (push && srt_pkg::action_type'(action) != srt_pkg::ACT_NONE) begin
               cmd_in.action  = srt_pkg::action_type'(action);
               cmd_in.gen     = generator_key;
               cmd_in.msg     = message_key;
               cmd_in.seq     = segment_number[5:0];
               cmd_in.fin     = final_segment;
               cmd_in.handle  = payload_handle;
               cmd_in.too_big = (segment_number[30:6] != '0)
                             || (7'(segment_number[5:0]) >= 7'(MAX_SEGMENTS));
               key_in   = generator_key ^ message_key;
               state_in = HASH;
            end
         end
         HASH: begin
            // quotient of the key by the bucket count
            quo_in   = 32'(prod >> (32 + BW));
            state_in = FOLD;
         end
         FOLD: begin
            rem_in   = BW'(key_ff - quo_ff * 32'(BUCKETS));
            state_in = SEND;
         end
         SEND: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff  <= key_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cmd_ff  <= cmd_in;
   end

   assign full = (state_ff != IDLE);

   srt_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .full  (q_full),
      .wdata ({cmd_ff, rem_ff}),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   assign q_cmd = q_rdata[QW-1:BW];
   assign q_bkt = q_rdata[BW-1:0];

endmodule

// ===== design/srt_engine.sv =====
module srt_engine #(
   parameter int BUCKETS      = 256,
   parameter int WAYS         = 4,
   parameter int MAX_SEGMENTS = 32,
   localparam int BW          = $clog2(BUCKETS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  srt_pkg::cmd_type  q_cmd,
   input  logic [BW-1:0]     q_bkt,
   input  logic              r_full,
   output logic              r_push,
   output srt_pkg::rsp_type  r_item
);
   localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SW  = $clog2(MAX_SEGMENTS);
   localparam int CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int HAW = $clog2(BUCKETS * WAYS * MAX_SEGMENTS);

   typedef struct packed {
      logic                    valid;
      logic [31:0]             gen;
      logic [31:0]             msg;
      logic [CW-1:0]           total;
      logic [CW-1:0]           count;
      logic [MAX_SEGMENTS-1:0] map;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   typedef enum logic [2:0] {CLEAR, IDLE, LOOK, UPDATE, SCAN, EMIT} state_type;

   row_type          row_mem [BUCKETS];
   logic [15:0]      hmem [BUCKETS * WAYS * MAX_SEGMENTS];

   state_type        state_ff, state_in;
   logic [BW-1:0]    clr_ff, clr_in;
   srt_pkg::cmd_type cmd_ff, cmd_in;
   logic [BW-1:0]    bkt_ff, bkt_in;
   row_type          rd_row_ff;
   row_type          row_ff, row_in;
   logic             hit_ff, hit_in;
   logic             room_ff, room_in;
   logic [WW-1:0]    way_ff, way_in;
   logic [MAX_SEGMENTS-1:0] rem_ff, rem_in;
   logic [SW-1:0]    cur_ff, cur_in;
   logic [15:0]      hd_ff;

   logic             row_we;
   logic [BW-1:0]    row_wa;
   row_type          row_wd;
   logic             row_re;
   logic             h_we, h_re;
   logic [HAW-1:0]   h_addr;

   // bucket lookup
   logic             hit_any, free_any;
   logic [WW-1:0]    hit_way, free_way;

   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_row_ff[w].valid && rd_row_ff[w].gen == cmd_ff.gen
             && rd_row_ff[w].msg == cmd_ff.msg) begin
            hit_any = 1'b1;
            hit_way = WW'(w);
         end
         if (!rd_row_ff[w].valid) begin
            free_any = 1'b1;
            free_way = WW'(w);
         end
      end
   end

   // insert update of the chosen way
   way_type                 base_w, new_w;
   logic [SW-1:0]           seqi;
   logic [MAX_SEGMENTS-1:0] bitm;
   logic                    dup, complete;

   always_comb begin
      seqi = cmd_ff.seq[SW-1:0];
      bitm = MAX_SEGMENTS'(1) << seqi;
      if (hit_ff) begin
         base_w = row_ff[way_ff];
      end else begin
         base_w       = '0;
         base_w.valid = 1'b1;
         base_w.gen   = cmd_ff.gen;
         base_w.msg   = cmd_ff.msg;
      end
      dup   = (base_w.map & bitm) != '0;
      new_w = base_w;
      if (cmd_ff.fin) begin
         new_w.total = CW'(seqi) + CW'(1);
      end
      if (!dup) begin
         new_w.map   = base_w.map | bitm;
         new_w.count = base_w.count + CW'(1);
      end
      complete = (new_w.total != '0) && (new_w.count == new_w.total);
   end

   logic [MAX_SEGMENTS-1:0] rem_next;
   assign rem_next = rem_ff & ~(MAX_SEGMENTS'(1) << cur_ff);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cmd_in   = cmd_ff;
      bkt_in   = bkt_ff;
      row_in   = row_ff;
      hit_in   = hit_ff;
      room_in  = room_ff;
      way_in   = way_ff;
      rem_in   = rem_ff;
      cur_in   = cur_ff;
      q_pop    = 1'b0;
      r_push   = 1'b0;
      r_item   = '0;
      r_item.last = 1'b1;
      row_we   = 1'b0;
      row_wa   = bkt_ff;
      row_wd   = row_ff;
      row_re   = 1'b0;
      h_we     = 1'b0;
      h_re     = 1'b0;
      h_addr   = HAW'((HAW'(bkt_ff) * HAW'(WAYS) + HAW'(way_ff)) * HAW'(MAX_SEGMENTS)
                      + HAW'(seqi));
      unique case (state_ff)
         CLEAR: begin
            row_we = 1'b1;
            row_wa = clr_ff;
            row_wd = '0;
            clr_in = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               row_re   = 1'b1;
               cmd_in   = q_cmd;
               bkt_in   = q_bkt;
               state_in = LOOK;
            end
         end
         LOOK: begin
            row_in  = rd_row_ff;
            hit_in  = hit_any;
            room_in = hit_any || free_any;
            way_in  = hit_any ? hit_way : free_way;
            rem_in  = rd_row_ff[hit_way].map;
            cur_in  = '0;
            if (cmd_ff.action == srt_pkg::ACT_READ && hit_any
                && rd_row_ff[hit_way].map != '0) begin
               state_in = SCAN;
            end else begin
               state_in = UPDATE;
            end
         end
         UPDATE: begin
            if (!r_full) begin
               r_push   = 1'b1;
               state_in = IDLE;
               unique case (cmd_ff.action)
                  srt_pkg::ACT_INSERT: begin
                     if (cmd_ff.too_big || !room_ff) begin
                        r_item.status = srt_pkg::ST_NO_ROOM;
                     end else begin
                        row_we = 1'b1;
                        row_wd[way_ff] = new_w;
                        h_we   = !dup;
                        if (dup) begin
                           r_item.status = complete ? srt_pkg::ST_DUP_COMPLETE
                                                    : srt_pkg::ST_DUP;
                        end else begin
                           r_item.status = complete ? srt_pkg::ST_ADDED_COMPLETE
                                                    : srt_pkg::ST_ADDED;
                        end
                     end
                  end
                  srt_pkg::ACT_RELEASE: begin
                     if (hit_ff) begin
                        row_we = 1'b1;
                        row_wd[way_ff].valid = 1'b0;
                        r_item.status = srt_pkg::ST_RELEASED;
                     end else begin
                        r_item.status = srt_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: r_item.status = srt_pkg::ST_NOT_FOUND;
               endcase
            end
         end
         SCAN: begin
            // step the cursor to the next present segment
            h_addr = HAW'((HAW'(bkt_ff) * HAW'(WAYS) + HAW'(way_ff)) * HAW'(MAX_SEGMENTS)
                          + HAW'(cur_ff));
            if (rem_ff[cur_ff]) begin
               h_re     = 1'b1;
               state_in = EMIT;
            end else begin
               cur_in = cur_ff + SW'(1);
            end
         end
         EMIT: begin
            if (!r_full) begin
               r_push        = 1'b1;
               r_item.status = srt_pkg::ST_SEGMENT;
               r_item.seg    = 5'(cur_ff);
               r_item.handle = hd_ff;
               r_item.last   = (rem_next == '0);
               rem_in        = rem_next;
               cur_in        = cur_ff + SW'(1);
               state_in      = (rem_next == '0) ? IDLE : SCAN;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      cmd_ff  <= cmd_in;
      bkt_ff  <= bkt_in;
      row_ff  <= row_in;
      hit_ff  <= hit_in;
      room_ff <= room_in;
      way_ff  <= way_in;
      rem_ff  <= rem_in;
      cur_ff  <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      if (row_re) begin
         rd_row_ff <= row_mem[q_bkt];
      end
   end

   always_ff @(posedge clock) begin
      if (h_we) begin
         hmem[h_addr] <= cmd_ff.handle;
      end
      if (h_re) begin
         hd_ff <= hmem[h_addr];
      end
   end

endmodule
